[sv/clcd_pkg.sv]
// Shared types, constants and nibble-program tables for the character LCD controller.
// No dependencies; every other file in this folder uses it through scoped names.

package clcd_pkg;

    // Display geometry
    localparam int COLUMNS = 20;
    localparam int ROWS    = 4;

    // Centering is skipped for lengths above this
    localparam int CENTRE_MAX_LEN = 20;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int ROW_W   = 2;
    localparam int NIB_W   = 4;
    localparam int DELAY_W = 6;
    localparam int STEP_W  = 4;

    // Input and output bus widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QLVL_W = 2;

    // Instruction bytes
    localparam logic [BYTE_W-1:0] INS_FUNC_SET  = 8'h28;
    localparam logic [BYTE_W-1:0] INS_DISP_ON   = 8'h0C;
    localparam logic [BYTE_W-1:0] INS_CLEAR     = 8'h01;
    localparam logic [BYTE_W-1:0] INS_HOME      = 8'h02;
    localparam logic [BYTE_W-1:0] INS_SET_ADDR  = 8'h80;
    localparam logic [BYTE_W-1:0] INS_ENTRY     = 8'h06;
    localparam logic [BYTE_W-1:0] INS_WAKE      = 8'h03;
    localparam logic [BYTE_W-1:0] INS_BUS4      = 8'h02;
    localparam logic [BYTE_W-1:0] ROW_ODD_BASE  = 8'h40;

    // Command codes on the input item
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_DATA   = 3'd2,
        CMD_RAW    = 3'd3,
        CMD_SETCUR = 3'd4,
        CMD_NEWLN  = 3'd5,
        CMD_CLEAR  = 3'd6,
        CMD_CENTRE = 3'd7
    } cmd_t;

    // Nibble programs the front hands to the back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_DATA,
        OP_DATA_ADDR,
        OP_INSTR,
        OP_ADDR,
        OP_CLEAR
    } op_t;

    // One input item
    typedef struct packed {
        logic [BYTE_W-1:0] text_length;
        logic [BYTE_W-1:0] row;
        logic [BYTE_W-1:0] column;
        logic [BYTE_W-1:0] value;
        logic [CMD_W-1:0]  command;
    } item_t;

    // One queue entry: a byte (two nibbles) or a single nibble
    typedef struct packed {
        logic               single;
        logic               rs;
        logic [BYTE_W-1:0]  data;
        logic [DELAY_W-1:0] delay;
        logic               last;
    } entry_t;

    function automatic logic [BYTE_W-1:0] row_offset(input logic [ROW_W-1:0] r);
        logic [BYTE_W-1:0] off;
        unique case (r)
            2'd0:    off = '0;
            2'd1:    off = ROW_ODD_BASE;
            2'd2:    off = BYTE_W'(COLUMNS);
            default: off = BYTE_W'(COLUMNS) + ROW_ODD_BASE;
        endcase
        return off;
    endfunction

    function automatic entry_t mk_entry(input logic single, input logic rs,
                                        input logic [BYTE_W-1:0] data,
                                        input int unsigned delay, input logic last);
        entry_t e;
        e.single = single;
        e.rs     = rs;
        e.data   = data;
        e.delay  = DELAY_W'(delay);
        e.last   = last;
        return e;
    endfunction

    // Entry for one step of a program; last marks the final step
    function automatic entry_t step_entry(input op_t op, input logic [STEP_W-1:0] step,
                                          input logic [BYTE_W-1:0] val,
                                          input logic [BYTE_W-1:0] addr);
        entry_t e;
        e = '0;
        unique case (op)
            OP_INIT: begin
                unique case (step)
                    4'd0:    e = mk_entry(1'b1, 1'b0, INS_WAKE, 50, 1'b0);
                    4'd1:    e = mk_entry(1'b1, 1'b0, INS_WAKE, 5, 1'b0);
                    4'd2:    e = mk_entry(1'b1, 1'b0, INS_WAKE, 5, 1'b0);
                    4'd3:    e = mk_entry(1'b1, 1'b0, INS_BUS4, 1, 1'b0);
                    4'd4:    e = mk_entry(1'b0, 1'b0, INS_FUNC_SET, 0, 1'b0);
                    4'd5:    e = mk_entry(1'b0, 1'b0, INS_DISP_ON, 0, 1'b0);
                    4'd6:    e = mk_entry(1'b0, 1'b0, INS_CLEAR, 0, 1'b0);
                    4'd7:    e = mk_entry(1'b0, 1'b0, INS_HOME, 2, 1'b0);
                    4'd8:    e = mk_entry(1'b0, 1'b0, INS_SET_ADDR, 2, 1'b0);
                    default: e = mk_entry(1'b0, 1'b0, INS_ENTRY, 0, 1'b1);
                endcase
            end
            OP_DATA:  e = mk_entry(1'b0, 1'b1, val, 0, 1'b1);
            OP_DATA_ADDR: begin
                if (step == '0) begin
                    e = mk_entry(1'b0, 1'b1, val, 0, 1'b0);
                end else begin
                    e = mk_entry(1'b0, 1'b0, addr, 0, 1'b1);
                end
            end
            OP_INSTR: e = mk_entry(1'b0, 1'b0, val, 0, 1'b1);
            OP_ADDR:  e = mk_entry(1'b0, 1'b0, addr, 0, 1'b1);
            OP_CLEAR: begin
                unique case (step)
                    4'd0:    e = mk_entry(1'b0, 1'b0, INS_CLEAR, 0, 1'b0);
                    4'd1:    e = mk_entry(1'b0, 1'b0, INS_HOME, 2, 1'b0);
                    default: e = mk_entry(1'b0, 1'b0, INS_SET_ADDR, 2, 1'b1);
                endcase
            end
            default:  e = '0;
        endcase
        return e;
    endfunction

endpackage

[sv/clcd_front.sv]
// Front end: accepts commands, tracks the cursor and feeds byte entries to the queue.
// Depends on clcd_pkg.

module clcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  clcd_pkg::item_t   item,
    input  logic              q_space,
    output logic              push,
    output clcd_pkg::entry_t  push_entry
);

    logic                              busy_reg, busy_next;
    logic [clcd_pkg::STEP_W-1:0]       step_reg, step_next;
    clcd_pkg::op_t                     op_reg, op_next;
    logic [clcd_pkg::BYTE_W-1:0]       val_reg, val_next;
    logic [clcd_pkg::BYTE_W-1:0]       addr_reg, addr_next;
    logic [clcd_pkg::BYTE_W-1:0]       col_reg, col_next;
    logic [clcd_pkg::ROW_W-1:0]        row_reg, row_next;

    logic                              accept;
    clcd_pkg::op_t                     acc_op;
    logic [clcd_pkg::BYTE_W-1:0]       acc_col, col_sel, col_inc;
    logic [clcd_pkg::ROW_W-1:0]        acc_row, row_sel, row_adv, row_clamp;
    logic [clcd_pkg::BYTE_W-1:0]       acc_addr;
    logic                              wrap, len_ok;
    logic signed [clcd_pkg::BYTE_W:0]  diff, centre_col;

    assign push_entry = clcd_pkg::step_entry(op_reg, step_reg, val_reg, addr_reg);
    assign push       = busy_reg && q_space;
    assign in_ready   = !busy_reg || (q_space && push_entry.last);
    assign accept     = in_valid && in_ready;

    assign col_inc = col_reg + 8'd1;
    assign wrap    = col_inc >= clcd_pkg::BYTE_W'(clcd_pkg::COLUMNS);
    assign row_adv = (row_reg == clcd_pkg::ROW_W'(clcd_pkg::ROWS - 1)) ? '0 : row_reg + 2'd1;
    assign row_clamp = (item.row >= clcd_pkg::BYTE_W'(clcd_pkg::ROWS))
                     ? clcd_pkg::ROW_W'(clcd_pkg::ROWS - 1) : item.row[clcd_pkg::ROW_W-1:0];
    assign len_ok  = item.text_length <= clcd_pkg::BYTE_W'(clcd_pkg::CENTRE_MAX_LEN);

    // Signed halving, truncated toward zero
    assign diff       = $signed(9'(clcd_pkg::COLUMNS)) - $signed({1'b0, item.text_length});
    assign centre_col = $signed(diff + {8'd0, diff[clcd_pkg::BYTE_W]}) >>> 1;

    // Classify the command and work out the cursor it leaves
    always_comb begin
        acc_op  = clcd_pkg::OP_NONE;
        acc_col = col_reg;
        acc_row = row_reg;
        col_sel = '0;
        row_sel = '0;
        unique case (clcd_pkg::cmd_t'(item.command))
            clcd_pkg::CMD_INIT: begin
                acc_op  = clcd_pkg::OP_INIT;
                acc_col = '0;
                acc_row = '0;
            end
            clcd_pkg::CMD_WRITE: begin
                row_sel = row_adv;
                if (wrap) begin
                    acc_op  = clcd_pkg::OP_DATA_ADDR;
                    acc_col = '0;
                    acc_row = row_adv;
                end else begin
                    acc_op  = clcd_pkg::OP_DATA;
                    acc_col = col_inc;
                end
            end
            clcd_pkg::CMD_DATA:  acc_op = clcd_pkg::OP_DATA;
            clcd_pkg::CMD_RAW:   acc_op = clcd_pkg::OP_INSTR;
            clcd_pkg::CMD_SETCUR: begin
                acc_op  = clcd_pkg::OP_ADDR;
                col_sel = item.column;
                row_sel = row_clamp;
                acc_col = item.column;
                acc_row = row_clamp;
            end
            clcd_pkg::CMD_NEWLN: begin
                acc_op  = clcd_pkg::OP_ADDR;
                row_sel = row_adv;
                acc_col = '0;
                acc_row = row_adv;
            end
            clcd_pkg::CMD_CLEAR: begin
                acc_op  = clcd_pkg::OP_CLEAR;
                acc_col = '0;
                acc_row = '0;
            end
            default: begin
                col_sel = centre_col[clcd_pkg::BYTE_W-1:0];
                row_sel = row_reg;
                if (len_ok) begin
                    acc_op  = clcd_pkg::OP_ADDR;
                    acc_col = centre_col[clcd_pkg::BYTE_W-1:0];
                end
            end
        endcase
    end

    assign acc_addr = clcd_pkg::INS_SET_ADDR | (col_sel + clcd_pkg::row_offset(row_sel));

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        op_next   = op_reg;
        val_next  = val_reg;
        addr_next = addr_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            busy_next = (acc_op != clcd_pkg::OP_NONE);
            step_next = '0;
            op_next   = acc_op;
            val_next  = item.value;
            addr_next = acc_addr;
            col_next  = acc_col;
            row_next  = acc_row;
        end else if (push && push_entry.last) begin
            busy_next = 1'b0;
        end else if (push) begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
        step_reg <= step_next;
        op_reg   <= op_next;
        val_reg  <= val_next;
        addr_reg <= addr_next;
    end

endmodule

[sv/clcd_queue.sv]
// Two-entry queue of byte entries between front and back.
// Depends on clcd_pkg.

module clcd_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  clcd_pkg::entry_t              push_entry,
    input  logic                          pop,
    output clcd_pkg::entry_t              head,
    output logic [clcd_pkg::QLVL_W-1:0]   level
);

    clcd_pkg::entry_t                  mem [clcd_pkg::QDEPTH];
    logic [clcd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [clcd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [clcd_pkg::QLVL_W-1:0]       level_reg, level_next;

    assign head  = mem[rd_ptr_reg];
    assign level = level_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + clcd_pkg::QLVL_W'(push) - clcd_pkg::QLVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

[sv/clcd_back.sv]
// Back end: splits byte entries into high and low nibbles, or passes a single nibble, into the output register.
// Depends on clcd_pkg.

module clcd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  clcd_pkg::entry_t              head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_rs,
    output logic [clcd_pkg::NIB_W-1:0]    out_nibble,
    output logic [clcd_pkg::DELAY_W-1:0]  out_delay,
    output logic                          out_last
);

    logic                          valid_reg, valid_next;
    logic                          half_reg, half_next;
    logic                          rs_reg, rs_next;
    logic [clcd_pkg::NIB_W-1:0]    nib_reg, nib_next;
    logic [clcd_pkg::DELAY_W-1:0]  delay_reg, delay_next;
    logic                          last_reg, last_next;
    logic                          load;

    assign load = head_valid && (!valid_reg || out_ready);

    always_comb begin
        valid_next = valid_reg && !out_ready;
        half_next  = half_reg;
        rs_next    = rs_reg;
        nib_next   = nib_reg;
        delay_next = delay_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            rs_next    = head.rs;
            if (head.single) begin
                nib_next   = head.data[clcd_pkg::NIB_W-1:0];
                delay_next = head.delay;
                last_next  = head.last;
                pop        = 1'b1;
            end else if (!half_reg) begin
                nib_next   = head.data[clcd_pkg::BYTE_W-1:clcd_pkg::NIB_W];
                delay_next = head.delay;
                last_next  = 1'b0;
                half_next  = 1'b1;
            end else begin
                nib_next   = head.data[clcd_pkg::NIB_W-1:0];
                delay_next = '0;
                last_next  = head.last;
                half_next  = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
        rs_reg    <= rs_next;
        nib_reg   <= nib_next;
        delay_reg <= delay_next;
        last_reg  <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_rs     = rs_reg;
    assign out_nibble = nib_reg;
    assign out_delay  = delay_reg;
    assign out_last   = last_reg;

endmodule

[sv/char_lcd_4bit_controller_core.sv]
// Top level of the 4-bit character LCD controller: front, queue and back.
// Depends on clcd_pkg, clcd_front, clcd_queue and clcd_back.
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------------
//   s_      | in        | command item: command, value, column, row, length
//   m_      | out       | bus nibble: register select, nibble, delay, last
//
// The output runs at one nibble per cycle while m_tready holds, the back end splitting
// each byte into two nibbles and passing single-nibble entries through as they are.
// A centre command with a length over 20 yields nothing.
// Reset clears the cursor to row 0, column 0, empties the queue and drops
// the output valid; no clearing pass is needed.
// The front keeps accepting while the output stalls until the queue fills.

module char_lcd_4bit_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tdata: command[2:0], value[10:3], column[18:11], row[26:19],
    //        text_length[34:27], zero pad[39:35]
    input  logic [clcd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: nibble[3:0], delay_before_ms[9:4], zero pad[15:10]
    output logic [clcd_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: reg_select[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    clcd_pkg::item_t                  item;
    clcd_pkg::entry_t                 push_entry;
    clcd_pkg::entry_t                 head;
    logic                             push;
    logic                             pop;
    logic                             q_space;
    logic [clcd_pkg::QLVL_W-1:0]      q_level;
    logic [clcd_pkg::NIB_W-1:0]       out_nibble;
    logic [clcd_pkg::DELAY_W-1:0]     out_delay;

    // Unpack the command item; the top pad bits carry nothing
    assign item = clcd_pkg::item_t'(s_tdata[$bits(clcd_pkg::item_t)-1:0]);

    // Hold the front whenever the queue is full
    assign q_space = q_level < clcd_pkg::QLVL_W'(clcd_pkg::QDEPTH);

    clcd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .item       (item),
        .q_space    (q_space),
        .push       (push),
        .push_entry (push_entry)
    );

    clcd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .level      (q_level)
    );

    clcd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_level != '0),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rs     (m_tuser),
        .out_nibble (out_nibble),
        .out_delay  (out_delay),
        .out_last   (m_tlast)
    );

    // Pack the result nibble, zero pad to whole bytes
    assign m_tdata = {{(clcd_pkg::M_TDATA_W - clcd_pkg::DELAY_W - clcd_pkg::NIB_W){1'b0}},
                      out_delay, out_nibble};

`ifndef ASSERT_OFF
    // The queue never holds more than its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= clcd_pkg::QLVL_W'(clcd_pkg::QDEPTH))
        else $error("queue level above depth");

    // Data nibbles never carry a wait
    a_data_no_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (out_delay == '0))
        else $error("data nibble with nonzero delay");

    // A delayed nibble opens a byte or stands alone, so it never closes an item
    a_delay_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_delay != '0)) |-> !m_tlast)
        else $error("delayed nibble marked last");
`endif

endmodule
